// ===== rtl/slb_pkg.sv =====
// shared types and constants of the scrolling line edit buffer
package slb_pkg;

    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 8;
    localparam int LINE_DEPTH = 256;
    localparam int OP_W       = 3;
    localparam int COL_OUT_W  = 5;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_LEFT   = 3'd1,
        OP_RIGHT  = 3'd2,
        OP_BACK   = 3'd3,
        OP_ENTER  = 3'd4,
        OP_BREAK  = 3'd5,
        OP_BEGIN  = 3'd6,
        OP_READ   = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_WRCH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_ram_req;

endpackage

// ===== rtl/slb_line_ram.sv =====
// line store: one write port, one read port, registered read data
module slb_line_ram (
    input  logic                  i_clk,
    input  slb_pkg::t_ram_req     i_req,
    output logic [slb_pkg::BYTE_W-1:0] o_rd_data
);

    logic [slb_pkg::BYTE_W-1:0] r_mem [slb_pkg::LINE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            o_rd_data <= r_mem[i_req.rd_addr];
        end
    end

endmodule

// ===== rtl/scrolling_line_edit_buffer_top.sv =====
// top level of the scrolling line edit buffer: edit sequencer around the line store
//
// Slave channel takes one edit word: tuser carries the operation, tdata the byte to
// insert and the line position to read. Master channel returns one result word per
// edit: cursor column, window offset, line length, read byte and the accepted,
// committed and cancelled flags.
// The block works on one word at a time; o_s_tready is high only while it is idle.
// Insert shifts the line tail behind the cursor up by one byte and then writes the
// new byte; backspace shifts the tail down by one byte; every other operation goes
// straight to the done state. The shift runs through the single read and write
// port of the line store, one byte a cycle.
// A finished result is held in the output register; a new word is accepted while it
// waits, but the next result is not loaded until the receiver has taken it, so a
// stalled receiver stalls the block after one further word.
// Reset clears length, cursor column and window offset; the line store is not cleared
// and needs no sweep, so the block is ready as soon as reset is released.
module scrolling_line_edit_buffer_top #(
    parameter int WINDOW_WIDTH = 32,
    parameter int MAX_LINE     = 255
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [7:0] insert_char, [15:8] read_index
    input  logic [slb_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // [2:0] op
    input  logic [slb_pkg::OP_W-1:0]          i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [4:0] cursor_column, [12:5] window_offset, [20:13] line_length,
    // [28:21] read_byte, [29] accepted, [30] committed, [31] cancelled
    output logic [slb_pkg::OUT_DATA_W-1:0]    o_m_tdata
);

    localparam int CW = (WINDOW_WIDTH > 1) ? $clog2(WINDOW_WIDTH) : 1;
    localparam int PW = slb_pkg::ADDR_W + 1;

    slb_pkg::t_state                r_state, n_state;
    logic [slb_pkg::ADDR_W-1:0]     r_len, n_len;
    logic [CW-1:0]                  r_col, n_col;
    logic [slb_pkg::ADDR_W-1:0]     r_off, n_off;
    slb_pkg::t_op                   r_op, n_op;
    logic [slb_pkg::BYTE_W-1:0]     r_ch, n_ch;
    logic [slb_pkg::ADDR_W-1:0]     r_ridx, n_ridx;
    logic                           r_acc, n_acc;
    logic [slb_pkg::ADDR_W-1:0]     r_dst, n_dst;
    logic [slb_pkg::ADDR_W-1:0]     r_cnt, n_cnt;
    logic [slb_pkg::ADDR_W-1:0]     r_pos, n_pos;
    logic                           r_out_valid, n_out_valid;
    logic [slb_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    slb_pkg::t_ram_req              ram_req;
    logic [slb_pkg::BYTE_W-1:0]     rd_data;

    slb_pkg::t_op                   in_op;
    logic [PW-1:0]                  pos;
    logic [PW-1:0]                  gap;
    logic [CW-1:0]                  mr_col, ml_col;
    logic [slb_pkg::ADDR_W-1:0]     mr_off, ml_off;
    logic [slb_pkg::BYTE_W-1:0]     res_byte;
    logic [slb_pkg::COL_OUT_W-1:0]  res_col;

    slb_line_ram u_line_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    assign in_op = slb_pkg::t_op'(i_s_tuser);
    assign pos   = PW'(r_off) + PW'(r_col);
    assign gap   = PW'(r_len) - pos;

    // cursor moves, scrolling at the window edges
    always_comb begin
        mr_col = r_col;
        mr_off = r_off;
        if (r_col < CW'(WINDOW_WIDTH - 1)) begin
            mr_col = r_col + CW'(1);
        end else begin
            mr_off = r_off + 8'd1;
        end
        ml_col = r_col;
        ml_off = r_off;
        if (r_col != '0) begin
            ml_col = r_col - CW'(1);
        end else if (r_off != '0) begin
            ml_off = r_off - 8'd1;
        end
    end

    assign res_byte = (r_op == slb_pkg::OP_READ && r_ridx < r_len) ? rd_data : '0;
    assign res_col  = slb_pkg::COL_OUT_W'(r_col);

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_col       = r_col;
        n_off       = r_off;
        n_op        = r_op;
        n_ch        = r_ch;
        n_ridx      = r_ridx;
        n_acc       = r_acc;
        n_dst       = r_dst;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_out_valid = r_out_valid & ~i_m_tready;
        n_out_data  = r_out_data;
        ram_req     = '0;

        case (r_state)
            slb_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_op    = in_op;
                    n_ch    = i_s_tdata[7:0];
                    n_ridx  = i_s_tdata[15:8];
                    n_acc   = 1'b1;
                    n_state = slb_pkg::ST_DONE;
                    case (in_op)
                        slb_pkg::OP_INSERT: begin
                            if (r_len >= slb_pkg::ADDR_W'(MAX_LINE) || pos > PW'(r_len)) begin
                                n_acc = 1'b0;
                            end else begin
                                n_len           = r_len + 8'd1;
                                n_col           = mr_col;
                                n_off           = mr_off;
                                n_pos           = pos[slb_pkg::ADDR_W-1:0];
                                n_cnt           = gap[slb_pkg::ADDR_W-1:0];
                                n_dst           = r_len;
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = r_len - 8'd1;
                                n_state = (gap == '0) ? slb_pkg::ST_WRCH : slb_pkg::ST_SHIFT;
                            end
                        end
                        slb_pkg::OP_LEFT: begin
                            if (pos != '0) begin
                                n_col = ml_col;
                                n_off = ml_off;
                            end else begin
                                n_acc = 1'b0;
                            end
                        end
                        slb_pkg::OP_RIGHT: begin
                            if (pos < PW'(r_len)) begin
                                n_col = mr_col;
                                n_off = mr_off;
                            end else begin
                                n_acc = 1'b0;
                            end
                        end
                        slb_pkg::OP_BACK: begin
                            if (pos != '0 && pos <= PW'(r_len)) begin
                                n_len           = r_len - 8'd1;
                                n_col           = ml_col;
                                n_off           = ml_off;
                                n_cnt           = gap[slb_pkg::ADDR_W-1:0];
                                n_dst           = pos[slb_pkg::ADDR_W-1:0] - 8'd1;
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = pos[slb_pkg::ADDR_W-1:0];
                                if (gap != '0) begin
                                    n_state = slb_pkg::ST_SHIFT;
                                end
                            end else begin
                                n_acc = 1'b0;
                            end
                        end
                        slb_pkg::OP_BEGIN: begin
                            if (PW'(r_len) < PW'(WINDOW_WIDTH)) begin
                                n_off = '0;
                                n_col = CW'(r_len);
                            end else begin
                                n_off = slb_pkg::ADDR_W'(PW'(r_len) - PW'(WINDOW_WIDTH)
                                        + PW'(1));
                                n_col = CW'(WINDOW_WIDTH - 1);
                            end
                        end
                        slb_pkg::OP_READ: begin
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = i_s_tdata[15:8];
                        end
                        default: begin
                        end
                    endcase
                end
            end
            slb_pkg::ST_SHIFT: begin
                // write one byte of the tail while fetching the next one
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = r_dst;
                ram_req.wr_data = rd_data;
                ram_req.rd_en   = 1'b1;
                if (r_op == slb_pkg::OP_INSERT) begin
                    ram_req.rd_addr = r_dst - 8'd2;
                    n_dst           = r_dst - 8'd1;
                end else begin
                    ram_req.rd_addr = r_dst + 8'd2;
                    n_dst           = r_dst + 8'd1;
                end
                n_cnt = r_cnt - 8'd1;
                if (r_cnt == 8'd1) begin
                    n_state = (r_op == slb_pkg::OP_INSERT) ? slb_pkg::ST_WRCH
                                                           : slb_pkg::ST_DONE;
                end
            end
            slb_pkg::ST_WRCH: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = r_pos;
                ram_req.wr_data = r_ch;
                n_state         = slb_pkg::ST_DONE;
            end
            slb_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_op == slb_pkg::OP_BREAK, r_op == slb_pkg::OP_ENTER,
                                   r_acc, res_byte, r_len, r_off, res_col};
                    n_state     = slb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = slb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slb_pkg::ST_IDLE;
            r_len       <= '0;
            r_col       <= '0;
            r_off       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_col       <= n_col;
            r_off       <= n_off;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_ch       <= n_ch;
        r_ridx     <= n_ridx;
        r_acc      <= n_acc;
        r_dst      <= n_dst;
        r_cnt      <= n_cnt;
        r_pos      <= n_pos;
        r_out_data <= n_out_data;
    end

    assign o_s_tready = (r_state == slb_pkg::ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== sim/scrolling_line_edit_buffer_checker.sv =====
`timescale 1ns / 100ps
// result checker for the line edit buffer: tracks the line, cursor and window per edit word
module scrolling_line_edit_buffer_checker #(
    parameter int WINDOW_WIDTH = 32,
    parameter int MAX_LINE     = 255
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // [7:0] insert_char, [15:8] read_index
    input  logic [slb_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // [2:0] op
    input  logic [slb_pkg::OP_W-1:0]       i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // [4:0] cursor_column, [12:5] window_offset, [20:13] line_length,
    // [28:21] read_byte, [29] accepted, [30] committed, [31] cancelled
    input  logic [slb_pkg::OUT_DATA_W-1:0] i_m_tdata,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_refused,
    output int                             o_peak_length
);
    import slb_pkg::*;

    typedef struct packed {
        logic       cancelled;
        logic       committed;
        logic       accepted;
        logic [7:0] read_byte;
        logic [7:0] line_length;
        logic [7:0] window_offset;
        logic [4:0] cursor_column;
    } t_edit_result;

    logic [7:0]   line_text [LINE_DEPTH];
    int           text_length;
    int           cursor_col;
    int           window_left;
    t_edit_result awaited_results [$];
    int           fail_total;
    int           checked_total;
    int           refused_total;
    int           peak_total;

    function automatic void cursor_right();
        if (cursor_col < WINDOW_WIDTH - 1) begin
            cursor_col++;
        end else begin
            window_left = (window_left + 1) & 8'hFF;
        end
    endfunction

    function automatic void cursor_left();
        if (cursor_col > 0) begin
            cursor_col--;
        end else if (window_left > 0) begin
            window_left--;
        end
    endfunction

    // updates the line state for one edit word and returns the result word it yields
    function automatic t_edit_result apply_edit(input t_op op, input logic [7:0] ch,
                                                input logic [7:0] idx);
        t_edit_result r;
        int           cur;
        int           i;
        cur = window_left + cursor_col;
        r = '0;
        r.accepted = 1'b1;
        case (op)
            OP_INSERT: begin
                if (text_length >= MAX_LINE || cur > text_length) begin
                    r.accepted = 1'b0;
                end else begin
                    for (i = text_length; i > cur; i--)
                        line_text[i & 8'hFF] = line_text[(i - 1) & 8'hFF];
                    line_text[cur & 8'hFF] = ch;
                    text_length++;
                    cursor_right();
                end
            end
            OP_LEFT: begin
                if (cur > 0) cursor_left();
                else r.accepted = 1'b0;
            end
            OP_RIGHT: begin
                if (cur < text_length) cursor_right();
                else r.accepted = 1'b0;
            end
            OP_BACK: begin
                if (cur > 0 && cur <= text_length) begin
                    for (i = cur; i < text_length; i++)
                        line_text[(i - 1) & 8'hFF] = line_text[i & 8'hFF];
                    text_length--;
                    cursor_left();
                end else begin
                    r.accepted = 1'b0;
                end
            end
            OP_BEGIN: begin
                if (text_length < WINDOW_WIDTH) begin
                    window_left = 0;
                    cursor_col  = text_length;
                end else begin
                    window_left = text_length - WINDOW_WIDTH + 1;
                    cursor_col  = WINDOW_WIDTH - 1;
                end
            end
            OP_READ: begin
                r.read_byte = (idx < text_length) ? line_text[idx] : 8'h00;
            end
            default: ;
        endcase
        r.cursor_column = cursor_col[4:0];
        r.window_offset = window_left[7:0];
        r.line_length   = text_length[7:0];
        r.committed     = (op == OP_ENTER);
        r.cancelled     = (op == OP_BREAK);
        return r;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            fail_total++;
            $display("%0t ns: %s expected %0d got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_edit_result want;
        t_edit_result got;
        if (!i_rst_n) begin
            text_length   = 0;
            cursor_col    = 0;
            window_left   = 0;
            fail_total    = 0;
            checked_total = 0;
            refused_total = 0;
            peak_total    = 0;
            awaited_results.delete();
        end else begin
            // results first, so a word never matches the edit taken on the same edge
            if (i_m_tvalid && i_m_tready) begin
                got = t_edit_result'(i_m_tdata);
                if (awaited_results.size() == 0) begin
                    fail_total++;
                    $display("%0t ns: result word %h with no edit outstanding", $time, got);
                end else begin
                    want = awaited_results.pop_front();
                    checked_total++;
                    check_field("cursor column", want.cursor_column, got.cursor_column);
                    check_field("window offset", want.window_offset, got.window_offset);
                    check_field("line length", want.line_length, got.line_length);
                    check_field("read byte", want.read_byte, got.read_byte);
                    check_field("accepted", want.accepted, got.accepted);
                    check_field("committed", want.committed, got.committed);
                    check_field("cancelled", want.cancelled, got.cancelled);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                want = apply_edit(t_op'(i_s_tuser), i_s_tdata[7:0], i_s_tdata[15:8]);
                if (!want.accepted) refused_total++;
                if (text_length > peak_total) peak_total = text_length;
                awaited_results.push_back(want);
            end
        end
        o_fail_count  <= fail_total;
        o_pending     <= awaited_results.size();
        o_checked     <= checked_total;
        o_refused     <= refused_total;
        o_peak_length <= peak_total;
    end

endmodule

// ===== sim/tb_scrolling_line_edit_buffer_top.sv =====
`timescale 1ns / 100ps
// testbench top for the line edit buffer: edit stimulus, receiver stalls and verdict
module tb_scrolling_line_edit_buffer_top;
    import slb_pkg::*;

    localparam int EDIT_TOTAL   = 1350;
    localparam int FILL_EDITS   = 280;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 300;

    typedef enum int {
        MIX_FILL,
        MIX_GROW,
        MIX_ROAM,
        MIX_SHRINK,
        MIX_ANY
    } t_edit_mix;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;
    logic [OP_W-1:0]       i_s_tuser  = '0;
    logic                  i_m_tready = 1'b0;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    int fail_count;
    int pending;
    int checked;
    int refused;
    int peak_length;
    int edits_sent   = 0;
    int burst_left   = 0;
    bit hold_request = 1'b0;
    bit hold_done    = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    scrolling_line_edit_buffer_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    scrolling_line_edit_buffer_checker u_result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_refused     (refused),
        .o_peak_length (peak_length)
    );

    // offers one edit word, with a random gap whenever a burst runs out
    task automatic send_edit(input t_op op, input logic [7:0] ch, input logic [7:0] idx);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 8);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) < 2) ? $urandom_range(60, 200)
                                                    : $urandom_range(1, 24);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {idx, ch};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        burst_left--;
        edits_sent++;
    endtask

    function automatic t_op pick_op(input t_edit_mix mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                return (roll < 95) ? OP_INSERT : OP_READ;
            end
            MIX_GROW: begin
                if (roll < 65) return OP_INSERT;
                else if (roll < 75) return OP_LEFT;
                else if (roll < 85) return OP_RIGHT;
                else if (roll < 90) return OP_BACK;
                else return OP_READ;
            end
            MIX_ROAM: begin
                if (roll < 38) return OP_LEFT;
                else if (roll < 70) return OP_RIGHT;
                else if (roll < 78) return OP_BEGIN;
                else if (roll < 92) return OP_READ;
                else if (roll < 96) return OP_BACK;
                else if (roll < 98) return OP_ENTER;
                else return OP_BREAK;
            end
            MIX_SHRINK: begin
                if (roll < 55) return OP_BACK;
                else if (roll < 68) return OP_LEFT;
                else if (roll < 73) return OP_RIGHT;
                else if (roll < 81) return OP_BEGIN;
                else return OP_READ;
            end
            default: begin
                return t_op'($urandom_range(0, 7));
            end
        endcase
    endfunction

    initial begin
        t_edit_mix mix;
        int        remaining;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty line: reads, refused moves, begin, flags, then four inserts
        send_edit(OP_READ, 8'h00, 8'h00);
        send_edit(OP_READ, 8'hFF, 8'hFF);
        send_edit(OP_LEFT, 8'h00, 8'h00);
        send_edit(OP_RIGHT, 8'h00, 8'h00);
        send_edit(OP_BACK, 8'h00, 8'h00);
        send_edit(OP_BEGIN, 8'h00, 8'h00);
        send_edit(OP_ENTER, 8'h00, 8'h00);
        send_edit(OP_BREAK, 8'hFF, 8'hFF);
        send_edit(OP_INSERT, 8'h00, 8'hFF);
        send_edit(OP_INSERT, 8'hFF, 8'h00);
        send_edit(OP_INSERT, 8'hA5, 8'h5A);
        send_edit(OP_INSERT, 8'h5A, 8'hA5);
        // insert and delete in mid-line, right at the line end refused
        send_edit(OP_LEFT, 8'h00, 8'h00);
        send_edit(OP_LEFT, 8'h00, 8'h00);
        send_edit(OP_INSERT, 8'h3C, 8'h00);
        send_edit(OP_RIGHT, 8'h00, 8'h00);
        send_edit(OP_RIGHT, 8'h00, 8'h00);
        send_edit(OP_RIGHT, 8'h00, 8'h00);
        send_edit(OP_BACK, 8'h00, 8'h00);
        send_edit(OP_LEFT, 8'h00, 8'h00);
        send_edit(OP_BACK, 8'h00, 8'h00);
        send_edit(OP_BEGIN, 8'h00, 8'h00);
        send_edit(OP_READ, 8'h00, 8'h00);
        send_edit(OP_READ, 8'h00, 8'h01);
        send_edit(OP_READ, 8'h00, 8'hC8);

        // fill the line past its limit so full-line inserts get refused
        repeat (FILL_EDITS) send_edit(pick_op(MIX_FILL), 8'($urandom), 8'($urandom));
        hold_request = 1'b1;

        while (edits_sent < EDIT_TOTAL) begin
            mix       = t_edit_mix'($urandom_range(MIX_GROW, MIX_ANY));
            remaining = $urandom_range(20, 150);
            while (remaining > 0 && edits_sent < EDIT_TOTAL) begin
                send_edit(pick_op(mix), 8'($urandom), 8'($urandom));
                remaining--;
            end
        end
        i_s_tvalid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d edit words sent, %0d result words checked, %0d edits refused",
                 edits_sent, checked, refused);
        $display("line grew to %0d bytes with scrolling, full-line and empty-line edits",
                 peak_length);
        if (fail_count == 0) begin
            $display("[scrolling_line_edit_buffer_top] OK");
        end else begin
            $display("[scrolling_line_edit_buffer_top] ERROR");
        end
        $finish;
    end

    // receiver: runs of ready and stall, plus one long hold-off to back the block up
    initial begin
        int run_left;
        bit ready_now;
        run_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_done) begin
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
                run_left  = 0;
            end else if (run_left == 0) begin
                ready_now = ($urandom_range(0, 99) < 70);
                if (ready_now)
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 800)
                                                           : $urandom_range(1, 20);
                else
                    run_left = $urandom_range(1, 12);
                i_m_tready <= ready_now;
            end else begin
                run_left--;
            end
        end
    end

    initial begin
        #40_000_000;
        $display("[scrolling_line_edit_buffer_top] ERROR");
        $finish;
    end

endmodule
